FILE: rtl/iiea_pkg.sv
// Shared types and constants for the indexed insert/erase array.
package iiea_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int KIND_W = 2;
    localparam int STS_W  = 2;
    localparam int CNT_W  = 5;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

    // Response status codes.
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd3;

    // Word returned by a failed read.
    localparam logic signed [DATA_W-1:0] RD_FAIL = -32'sd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch and decode the request transaction
        logic step;      // move one entry per cycle through the RAM
        logic commit;    // final write, count update, build the result
        logic load_out;  // move the result into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;      // entries still moving
        logic out_free;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

FILE: rtl/iiea_stream_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface iiea_req_if;
    import iiea_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] write_data;

    modport source (output valid, output kind, output index, output write_data, input ready);
    modport sink   (input valid, input kind, input index, input write_data, output ready);
endinterface

interface iiea_rsp_if;
    import iiea_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_data;
    logic [STS_W-1:0]         status;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

FILE: rtl/indexed_insert_erase_array_top.sv
// Top level of the indexed insert/erase array.
// An ordered list of up to DEPTH signed 32-bit words kept packed at positions
// 0 to count-1 in one RAM with a write port and a registered read port. Each
// request transaction reads, inserts before, or erases at an index and yields
// exactly one response transaction with the read word (-1 on a failed read,
// zero for other kinds), a status (ok, out of range, full, empty) and the
// count after the request; a failed request changes nothing. One request is
// handled at a time: the next request is accepted only after the response to
// the last one has been loaded into the output register. An insert or erase
// moves M entries, M being count - index for an insert and count - index - 1
// for an erase; the RAM moves one entry per cycle, and each moved entry is
// written in the cycle after its read.
// A stalled response holds the controller until the output register is free.
// The reported count is the low 5 bits of the stored count.
module indexed_insert_erase_array_top #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iiea_req_if.sink     i_req,
    iiea_rsp_if.source   o_rsp
);
    import iiea_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    // Request sequencing.
    iiea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    // Storage, decode and response register.
    iiea_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_req.kind),
        .i_index       (i_req.index),
        .i_write_data  (i_req.write_data),
        .i_out_ready   (o_rsp.ready),
        .o_sts         (sts),
        .o_out_valid   (o_rsp.valid),
        .o_read_data   (o_rsp.read_data),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

`ifndef SYNTHESIS
    // After a request is taken, no further request is taken until it is done.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending response");

    // Controller commands are mutually exclusive.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.step, cmd.commit, cmd.load_out}))
        else $error("more than one controller command at once");

    // Once the moves are finished the request is committed in the next cycle.
    a_commit_after_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && !sts.busy) |=> cmd.commit)
        else $error("request not committed after the moves finished");
`endif
endmodule

FILE: rtl/iiea_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module iiea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/iiea_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module iiea_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  iiea_pkg::t_dp_sts     i_sts,
    output logic                  o_in_ready,
    output iiea_pkg::t_ctrl_cmd   o_cmd
);
    import iiea_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WORK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WORK;
                end
            end
            S_WORK: begin
                o_cmd.step = 1'b1;
                if (!i_sts.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: rtl/iiea_datapath.sv
// Datapath: request decode, entry RAM with shift sequencing, count and output register.
module iiea_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  iiea_pkg::t_ctrl_cmd                    i_cmd,
    input  logic [iiea_pkg::KIND_W-1:0]            i_kind,
    input  logic [iiea_pkg::IDX_W-1:0]             i_index,
    input  logic signed [iiea_pkg::DATA_W-1:0]     i_write_data,
    input  logic                                   i_out_ready,
    output iiea_pkg::t_dp_sts                      o_sts,
    output logic                                   o_out_valid,
    output logic signed [iiea_pkg::DATA_W-1:0]     o_read_data,
    output logic [iiea_pkg::STS_W-1:0]             o_status,
    output logic [iiea_pkg::CNT_W-1:0]             o_entry_count
);
    import iiea_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    // Request and sequencing registers.
    logic [CW-1:0]             r_count;
    logic [KIND_W-1:0]         r_kind;
    logic [AW-1:0]             r_idx;
    logic signed [DATA_W-1:0]  r_wdata;
    logic [STS_W-1:0]          r_status;
    logic                      r_ok;
    logic [CW-1:0]             r_left;
    logic [AW-1:0]             r_rd_addr;
    logic [AW-1:0]             r_wr_addr;
    logic                      r_wr_pend;

    // Pending result and output register.
    logic signed [DATA_W-1:0]  r_res_rdata;
    logic [STS_W-1:0]          r_res_status;
    logic [CNT_W-1:0]          r_res_count;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_rdata;
    logic [STS_W-1:0]          r_out_status;
    logic [CNT_W-1:0]          r_out_count;

    // Decode of the incoming request.
    logic [XW-1:0]     ix_x;
    logic [XW-1:0]     cnt_x;
    logic [STS_W-1:0]  dec_status;
    logic [CW-1:0]     dec_left;
    logic [AW-1:0]     dec_rd_addr;
    logic              dec_ok;

    // RAM ports.
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     step_rd;
    logic [CW-1:0]            n_count;

    assign ix_x  = XW'(i_index);
    assign cnt_x = XW'(r_count);

    // Classify the request against the current count.
    always_comb begin
        dec_status  = ST_OK;
        dec_left    = '0;
        dec_rd_addr = AW'(ix_x);
        unique case (i_kind)
            KIND_READ: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else if (ix_x >= cnt_x) begin
                    dec_status = ST_RANGE;
                end
            end
            KIND_INSERT: begin
                if (cnt_x >= XW'(DEPTH)) begin
                    dec_status = ST_FULL;
                end else if (ix_x > cnt_x) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_left    = CW'(cnt_x - ix_x);
                    dec_rd_addr = AW'(cnt_x - XW'(1));
                end
            end
            KIND_ERASE: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else if (ix_x >= cnt_x) begin
                    dec_status = ST_RANGE;
                end else begin
                    dec_left    = CW'(cnt_x - ix_x - XW'(1));
                    dec_rd_addr = AW'(ix_x + XW'(1));
                end
            end
            default: begin
                dec_status = ST_RANGE;
            end
        endcase
    end

    assign dec_ok = (dec_status == ST_OK);

    // Latch the request and set up the entry moves.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_kind;
            r_idx     <= AW'(ix_x);
            r_wdata   <= i_write_data;
            r_status  <= dec_status;
            r_ok      <= dec_ok;
            r_rd_addr <= dec_rd_addr;
        end else if (step_rd) begin
            r_rd_addr <= (r_kind == KIND_INSERT) ? r_rd_addr - AW'(1) : r_rd_addr + AW'(1);
        end
    end

    // Move counter and pending write, one entry per cycle.
    assign step_rd = i_cmd.step && (r_left != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_wr_pend <= 1'b0;
        end else if (i_cmd.accept) begin
            r_left    <= dec_left;
            r_wr_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_left    <= step_rd ? r_left - CW'(1) : r_left;
            r_wr_pend <= step_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_rd) begin
            r_wr_addr <= (r_kind == KIND_INSERT) ? r_rd_addr + AW'(1) : r_rd_addr - AW'(1);
        end
    end

    // RAM port selection: the read serves a read request or a move,
    // the write serves a move or the final insert.
    assign ram_re    = (i_cmd.accept && dec_ok && (i_kind == KIND_READ)) || step_rd;
    assign ram_raddr = i_cmd.accept ? AW'(ix_x) : r_rd_addr;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        if (i_cmd.commit) begin
            ram_we    = r_ok && (r_kind == KIND_INSERT);
            ram_waddr = r_idx;
            ram_wdata = r_wdata;
        end else if (i_cmd.step) begin
            ram_we = r_wr_pend;
        end
    end

    iiea_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Count after a successful insert or erase.
    always_comb begin
        n_count = r_count;
        if (r_ok && (r_kind == KIND_INSERT)) begin
            n_count = r_count + CW'(1);
        end else if (r_ok && (r_kind == KIND_ERASE)) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Build the result of the request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_kind == KIND_READ) begin
                r_res_rdata <= r_ok ? $signed(ram_rdata) : RD_FAIL;
            end else begin
                r_res_rdata <= '0;
            end
            r_res_status <= r_status;
            r_res_count  <= CNT_W'(n_count);
        end
    end

    // Output register; it is free when empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rdata  <= r_res_rdata;
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
        end
    end

    assign o_sts.busy     = (r_left != '0) || r_wr_pend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rdata;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;
endmodule

FILE: sim/tb_indexed_insert_erase_array_top.sv
// Self-checking testbench for the indexed insert/erase array top level.
`timescale 1ns / 100ps

module tb_indexed_insert_erase_array_top;
    import iiea_pkg::*;

    localparam int DEPTH      = 16;
    localparam int N_RANDOM   = 1250;
    localparam int DRAIN_WAIT = 40;
    localparam int MAX_SHOWN  = 10;

    // The kind code that the block does not define.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Two copies of the list state: one steers stimulus generation ahead of
    // time, the other predicts responses as request transactions are accepted.
    localparam int LOOKAHEAD = 0;
    localparam int CHECKER   = 1;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] wdata;
        int                       sgap;
        int                       rstall;
        bit                       drain;
    } t_req_item;

    typedef struct {
        logic signed [DATA_W-1:0] read_data;
        logic [STS_W-1:0]         status;
        logic [CNT_W-1:0]         entry_count;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iiea_req_if req_if ();
    iiea_rsp_if rsp_if ();

    indexed_insert_erase_array_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic signed [DATA_W-1:0] list_words [2][DEPTH];
    int                       list_count [2];

    t_req_item req_pending_q[$];
    t_rsp_item rsp_due_q[$];
    t_rsp_item rsp_due;
    t_rsp_item rsp_got;

    bit req_taken;
    int rsp_stall_pct;
    int mismatches;
    int n_accepted;
    int n_checked;
    int status_seen [4];

    // Generation settings picked up by each queued request.
    int cur_sgap;
    int cur_rstall;
    bit drain_next;
    int n_directed;
    int last_phase;

    // Apply one request to a copy of the list and return the response it yields.
    function automatic t_rsp_item list_apply(input int who, input logic [KIND_W-1:0] kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic signed [DATA_W-1:0] wdata);
        t_rsp_item r;
        int        n;
        int        k;
        r.read_data = '0;
        r.status    = ST_OK;
        n           = list_count[who];
        case (kind)
            KIND_READ: begin
                if (n == 0) begin
                    r.status    = ST_EMPTY;
                    r.read_data = RD_FAIL;
                end else if (int'(idx) >= n) begin
                    r.status    = ST_RANGE;
                    r.read_data = RD_FAIL;
                end else begin
                    r.read_data = list_words[who][idx];
                end
            end
            KIND_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(idx) > n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = n; k > int'(idx); k--)
                        list_words[who][k] = list_words[who][k-1];
                    list_words[who][idx] = wdata;
                    list_count[who]      = n + 1;
                end
            end
            KIND_ERASE: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(idx) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = int'(idx) + 1; k < n; k++)
                        list_words[who][k-1] = list_words[who][k];
                    list_count[who] = n - 1;
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.entry_count = list_count[who][CNT_W-1:0];
        return r;
    endfunction

    // Data words lean on the extremes and on all-ones and zero.
    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return RD_FAIL;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // An index that hits a stored entry, or zero on an empty list.
    function automatic int stored_index();
        if (list_count[LOOKAHEAD] == 0)
            return 0;
        return $urandom_range(0, list_count[LOOKAHEAD] - 1);
    endfunction

    // Queue one request transaction and advance the look-ahead copy of the list.
    task automatic add_req(input logic [KIND_W-1:0] kind, input int idx,
                           input logic signed [DATA_W-1:0] wdata);
        t_req_item it;
        t_rsp_item ignored;
        it.kind    = kind;
        it.index   = idx[IDX_W-1:0];
        it.wdata   = wdata;
        it.sgap    = cur_sgap;
        it.rstall  = cur_rstall;
        it.drain   = drain_next;
        drain_next = 1'b0;
        ignored    = list_apply(LOOKAHEAD, it.kind, it.index, it.wdata);
        req_pending_q.push_back(it);
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display({"%0t: %s: expected data %0d status %0d count %0d, ",
                      "got data %0d status %0d count %0d"},
                     $realtime, what, rsp_due.read_data, rsp_due.status, rsp_due.entry_count,
                     rsp_got.read_data, rsp_got.status, rsp_got.entry_count);
    endtask

    // Monitor: predict on each accepted request, check each accepted response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                rsp_due_q.push_back(list_apply(CHECKER, req_if.kind, req_if.index,
                                               req_if.write_data));
                n_accepted++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_got.read_data   = rsp_if.read_data;
                rsp_got.status      = rsp_if.status;
                rsp_got.entry_count = rsp_if.entry_count;
                n_checked++;
                status_seen[rsp_got.status]++;
                if (rsp_due_q.size() == 0) begin
                    rsp_due = '{default: '0};
                    note_mismatch("response with none pending");
                end else begin
                    rsp_due = rsp_due_q.pop_front();
                    if (rsp_got.read_data !== rsp_due.read_data)
                        note_mismatch("read_data mismatch");
                    else if (rsp_got.status !== rsp_due.status)
                        note_mismatch("status mismatch");
                    else if (rsp_got.entry_count !== rsp_due.entry_count)
                        note_mismatch("entry_count mismatch");
                end
            end
        end
    end

    // Driver: present requests and back-pressure responses on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            if (!req_if.valid || req_taken) begin
                if (req_pending_q.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (req_pending_q[0].drain && rsp_due_q.size() != 0) begin
                    req_if.valid <= 1'b0;
                end else if ($urandom_range(0, 99) < req_pending_q[0].sgap) begin
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid      <= 1'b1;
                    req_if.kind       <= req_pending_q[0].kind;
                    req_if.index      <= req_pending_q[0].index;
                    req_if.write_data <= req_pending_q[0].wdata;
                    rsp_stall_pct     =  req_pending_q[0].rstall;
                    void'(req_pending_q.pop_front());
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        int phase;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_READ;
        req_if.index      = '0;
        req_if.write_data = '0;
        rsp_if.ready      = 1'b0;
        rsp_stall_pct     = 0;
        mismatches        = 0;
        n_accepted        = 0;
        n_checked         = 0;
        status_seen       = '{default: 0};
        for (int w = 0; w < 2; w++) begin
            list_count[w] = 0;
            for (int e = 0; e < DEPTH; e++)
                list_words[w][e] = '0;
        end
        cur_sgap   = 0;
        cur_rstall = 0;
        drain_next = 1'b0;

        // Directed requests: empty list, bad indexes, ends and middle, unused kind.
        add_req(KIND_READ, 0, '0);
        add_req(KIND_ERASE, 0, '0);
        add_req(KIND_UNUSED, 31, 32'sh5555_5555);
        add_req(KIND_INSERT, 1, 32'sd5);
        add_req(KIND_INSERT, 0, 32'sh7FFF_FFFF);
        add_req(KIND_INSERT, 1, 32'sh8000_0000);
        add_req(KIND_INSERT, 0, RD_FAIL);
        add_req(KIND_INSERT, 1, '0);
        add_req(KIND_INSERT, 5, 32'shAAAA_AAAA);
        add_req(KIND_READ, 0, '0);
        add_req(KIND_READ, 3, '0);
        add_req(KIND_READ, 4, '0);
        add_req(KIND_READ, 31, '0);
        add_req(KIND_ERASE, 4, '0);
        add_req(KIND_ERASE, 31, '0);
        add_req(KIND_ERASE, 1, '0);
        add_req(KIND_ERASE, 2, '0);
        add_req(KIND_ERASE, 0, '0);
        add_req(KIND_UNUSED, 0, 32'sh5555_5555);
        add_req(KIND_READ, 0, '0);
        add_req(KIND_ERASE, 0, '0);
        add_req(KIND_READ, 0, '0);
        n_directed = req_pending_q.size();

        // Random part: fill runs, drain runs and mixed runs with noise, in four
        // idling phases; the first request of each phase waits for all responses.
        last_phase = -1;
        while (req_pending_q.size() < n_directed + N_RANDOM) begin
            phase = (req_pending_q.size() - n_directed) * 4 / N_RANDOM;
            if (phase != last_phase) begin
                last_phase = phase;
                drain_next = 1'b1;
                case (phase)
                    0:       begin cur_sgap = 0;  cur_rstall = 0;  end
                    1:       begin cur_sgap = 54; cur_rstall = 0;  end
                    2:       begin cur_sgap = 0;  cur_rstall = 54; end
                    default: begin cur_sgap = 21; cur_rstall = 21; end
                endcase
            end
            if ($urandom_range(0, 99) == 0)
                drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                while (list_count[LOOKAHEAD] < DEPTH) begin
                    if ($urandom_range(0, 99) < 20 && list_count[LOOKAHEAD] > 0)
                        add_req(KIND_READ, stored_index(), rand_word());
                    else
                        add_req(KIND_INSERT, $urandom_range(0, list_count[LOOKAHEAD]),
                                rand_word());
                end
                repeat ($urandom_range(1, 2))
                    add_req(KIND_INSERT, $urandom_range(0, 31), rand_word());
                add_req(KIND_READ, $urandom_range(0, DEPTH - 1), rand_word());
            end else if (pick < 60) begin
                while (list_count[LOOKAHEAD] > 0) begin
                    if ($urandom_range(0, 99) < 20)
                        add_req(KIND_READ, stored_index(), rand_word());
                    else
                        add_req(KIND_ERASE, stored_index(), rand_word());
                end
                add_req(KIND_ERASE, $urandom_range(0, 31), rand_word());
                add_req(KIND_READ, $urandom_range(0, 31), rand_word());
            end else begin
                repeat ($urandom_range(5, 20)) begin
                    if ($urandom_range(0, 99) < 70) begin
                        case ($urandom_range(0, 2))
                            0: add_req(KIND_READ, stored_index(), rand_word());
                            1: add_req(KIND_INSERT, $urandom_range(0, list_count[LOOKAHEAD]),
                                       rand_word());
                            default: add_req(KIND_ERASE, stored_index(), rand_word());
                        endcase
                    end else begin
                        add_req(2'($urandom_range(0, 3)), $urandom_range(0, 31), rand_word());
                    end
                end
            end
        end

        // Synchronous reset, then release.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every response to come back.
        while (req_pending_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d responses to %0d requests over fill, drain and mixed runs",
                 n_checked, n_accepted);
        $display("Statuses seen: ok %0d, out of range %0d, full %0d, empty %0d; mismatches %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], mismatches);
        if (mismatches == 0) begin
            $display("PASS indexed_insert_erase_array_top");
        end else begin
            $display("FAIL indexed_insert_erase_array_top");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(64'd8_000_000);
        $display("Timeout with %0d requests queued and %0d responses pending",
                 req_pending_q.size(), rsp_due_q.size());
        $display("FAIL indexed_insert_erase_array_top");
        $finish;
    end

endmodule
